// File: design/assert_macros.svh
// Assertion macros shared by the predicate evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PFE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define PFE_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: design/pfe_pkg.sv
// Types, opcodes and register indexes of the postfix predicate evaluator.
`timescale 1ns / 1ps

package pfe_pkg;

  typedef logic [15:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [4:0]  match_cnt_t;

  // configuration register file
  localparam int NUM_REGS = 6;
  typedef logic [2:0] reg_idx_t;
  typedef logic [NUM_REGS-1:0][15:0] reg_file_t;

  localparam reg_idx_t REG_STATUS  = 3'd0;
  localparam reg_idx_t REG_QUALITY = 3'd1;
  localparam reg_idx_t REG_NPC     = 3'd2;
  localparam reg_idx_t REG_FAMILY  = 3'd3;
  localparam reg_idx_t REG_SHAPE   = 3'd4;
  localparam reg_idx_t REG_FRAME   = 3'd5;

  // opcodes
  localparam byte_t OP_PUSH0   = 8'h00;
  localparam byte_t OP_PUSH1   = 8'h01;
  localparam byte_t OP_NOT     = 8'h21; // '!'
  localparam byte_t OP_NPC     = 8'h23; // '#'
  localparam byte_t OP_END     = 8'h24; // '$'
  localparam byte_t OP_LIT     = 8'h25; // '%'
  localparam byte_t OP_AND     = 8'h26; // '&'
  localparam byte_t OP_QUALITY = 8'h2A; // '*'
  localparam byte_t OP_OR      = 8'h2B; // '+'
  localparam byte_t OP_FAMILY  = 8'h3A; // ':'
  localparam byte_t OP_LT      = 8'h3C; // '<'
  localparam byte_t OP_EQ      = 8'h3D; // '='
  localparam byte_t OP_GT      = 8'h3E; // '>'
  localparam byte_t OP_STATUS  = 8'h3F; // '?'
  localparam byte_t OP_SHAPE   = 8'h40; // '@', also base of shape lists
  localparam byte_t OP_LE      = 8'h5B; // '['
  localparam byte_t OP_GE      = 8'h5D; // ']'
  localparam byte_t OP_FRAME   = 8'h60; // '`', also base of frame lists
  localparam byte_t OP_SHAPE_LIST_LO = 8'h41; // 'A'
  localparam byte_t OP_SHAPE_LIST_HI = 8'h5A; // 'Z'
  localparam byte_t OP_FRAME_LIST_LO = 8'h61; // 'a'
  localparam byte_t OP_FRAME_LIST_HI = 8'h7A; // 'z'

  // what the next byte means
  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_LOW,
    PH_LIT_HIGH,
    PH_MATCH_HIGH
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    byte_t      low_byte;
    match_cnt_t remaining;
    logic       found;
    logic       on_frame;
  } eval_state_t;

  localparam eval_state_t EVAL_IDLE = '{
    phase: PH_OPCODE, low_byte: 8'h00, remaining: 5'd0, found: 1'b0, on_frame: 1'b0
  };

  // stack request: pop count, then optional push
  typedef struct packed {
    logic [1:0] pops;
    logic       push;
    word_t      value;
  } stack_req_t;

  typedef struct packed {
    logic is_end;
    logic verdict;
    logic unknown;
  } step_info_t;

endpackage

// File: design/pfe_decode.sv
// Byte decoder: next operand phase, stack request and flags for one script byte.
`timescale 1ns / 1ps

module pfe_decode (
  input  pfe_pkg::byte_t       script_byte,
  input  pfe_pkg::eval_state_t state,
  input  pfe_pkg::reg_file_t   regs,
  input  pfe_pkg::word_t       pop_a,
  input  pfe_pkg::word_t       pop_c,
  output pfe_pkg::eval_state_t state_next,
  output pfe_pkg::stack_req_t  req,
  output pfe_pkg::step_info_t  info
);
  import pfe_pkg::*;

  logic       shape_list;
  logic       frame_list;
  word_t      operand;
  logic       hit;
  logic       found_n;
  match_cnt_t rem_m1;

  // shared classification and operand compare
  always_comb begin
    shape_list = (script_byte >= OP_SHAPE_LIST_LO) && (script_byte <= OP_SHAPE_LIST_HI);
    frame_list = (script_byte >= OP_FRAME_LIST_LO) && (script_byte <= OP_FRAME_LIST_HI);
    operand    = {script_byte, state.low_byte};
    hit        = operand == (state.on_frame ? regs[REG_FRAME] : regs[REG_SHAPE]);
    found_n    = state.found | hit;
    rem_m1     = state.remaining - 5'd1;
  end

  // next phase and operand state
  always_comb begin
    state_next = state;
    unique case (state.phase)
      PH_LOW: begin
        state_next.low_byte = script_byte;
        state_next.phase    = (state.remaining != 5'd0) ? PH_MATCH_HIGH : PH_LIT_HIGH;
      end
      PH_LIT_HIGH: begin
        state_next.phase = PH_OPCODE;
      end
      PH_MATCH_HIGH: begin
        state_next.found     = found_n;
        state_next.remaining = rem_m1;
        state_next.phase     = (rem_m1 == 5'd0) ? PH_OPCODE : PH_LOW;
      end
      PH_OPCODE: begin
        if (shape_list) begin
          state_next.remaining = 5'(script_byte - OP_SHAPE);
          state_next.found     = 1'b0;
          state_next.on_frame  = 1'b0;
          state_next.phase     = PH_LOW;
        end else if (frame_list) begin
          state_next.remaining = 5'(script_byte - OP_FRAME);
          state_next.found     = 1'b0;
          state_next.on_frame  = 1'b1;
          state_next.phase     = PH_LOW;
        end else if (script_byte == OP_LIT) begin
          state_next.remaining = 5'd0;
          state_next.phase     = PH_LOW;
        end
      end
    endcase
  end

  // stack request and flags
  always_comb begin
    req  = '0;
    info = '0;
    unique case (state.phase)
      PH_LOW: begin
        req = '0;
      end
      PH_LIT_HIGH: begin
        req.push  = 1'b1;
        req.value = operand;
      end
      PH_MATCH_HIGH: begin
        // list closes: push whether any operand matched
        if (rem_m1 == 5'd0) begin
          req.push  = 1'b1;
          req.value = {15'd0, found_n};
        end
      end
      PH_OPCODE: begin
        if (!shape_list && !frame_list) begin
          unique case (script_byte)
            OP_PUSH0:   begin req.push = 1'b1; req.value = 16'd0; end
            OP_PUSH1:   begin req.push = 1'b1; req.value = 16'd1; end
            OP_END: begin
              req.pops     = 2'd1;
              info.is_end  = 1'b1;
              info.verdict = pop_a != 16'd0;
            end
            OP_LIT:     req = '0;
            OP_AND: begin
              req.pops  = 2'd2;
              req.push  = 1'b1;
              req.value = {15'd0, (pop_a != 16'd0) && (pop_c != 16'd0)};
            end
            OP_OR: begin
              req.pops  = 2'd2;
              req.push  = 1'b1;
              req.value = {15'd0, (pop_a != 16'd0) || (pop_c != 16'd0)};
            end
            OP_NOT: begin
              req.pops  = 2'd1;
              req.push  = 1'b1;
              req.value = {15'd0, pop_a == 16'd0};
            end
            OP_EQ: begin
              req.pops = 2'd2; req.push = 1'b1; req.value = {15'd0, pop_c == pop_a};
            end
            OP_GT: begin
              req.pops = 2'd2; req.push = 1'b1; req.value = {15'd0, pop_c > pop_a};
            end
            OP_LT: begin
              req.pops = 2'd2; req.push = 1'b1; req.value = {15'd0, pop_c < pop_a};
            end
            OP_GE: begin
              req.pops = 2'd2; req.push = 1'b1; req.value = {15'd0, pop_c >= pop_a};
            end
            OP_LE: begin
              req.pops = 2'd2; req.push = 1'b1; req.value = {15'd0, pop_c <= pop_a};
            end
            OP_STATUS:  begin req.push = 1'b1; req.value = regs[REG_STATUS];  end
            OP_QUALITY: begin req.push = 1'b1; req.value = regs[REG_QUALITY]; end
            OP_NPC:     begin req.push = 1'b1; req.value = regs[REG_NPC];     end
            OP_FAMILY:  begin req.push = 1'b1; req.value = regs[REG_FAMILY];  end
            OP_SHAPE:   begin req.push = 1'b1; req.value = regs[REG_SHAPE];   end
            OP_FRAME:   begin req.push = 1'b1; req.value = regs[REG_FRAME];   end
            default:    info.unknown = 1'b1;
          endcase
        end
      end
    endcase
  end

endmodule

// File: design/pfe_stack.sv
// Value stack held as a shift line: top at entry 0, with fill count and fault detect.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pfe_stack #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                restart,
  input  pfe_pkg::stack_req_t req,
  output pfe_pkg::word_t      pop_a,
  output pfe_pkg::word_t      pop_c,
  output logic                fault
);
  import pfe_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] after_pop;
  word_t         stk [STACK_DEPTH];
  logic [1:0]    avail;
  logic          under;
  logic          over;
  logic          do_push;

  // popped operands read as zero past the bottom
  assign pop_a = (count != '0) ? stk[0] : 16'd0;
  assign pop_c = (count >= CW'(2)) ? stk[1] : 16'd0;

  // pops first, then the push against the reduced count
  always_comb begin
    under      = CW'(req.pops) > count;
    avail      = under ? count[1:0] : req.pops;
    after_pop  = count - CW'(avail);
    over       = req.push && (after_pop == CW'(STACK_DEPTH));
    do_push    = req.push && !over;
    fault      = under || over;
    count_next = after_pop + CW'(do_push);
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      count <= CW'(1);
    end else if (en) begin
      count <= count_next;
    end
  end

  // entries: on a push, the net effect of the request shifts the line
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      stk[0] <= 16'd1;
    end else if (en && do_push) begin
      case (avail)
        2'd2: begin
          stk[0] <= req.value;
          for (int i = 1; i < STACK_DEPTH - 1; i++) begin
            stk[i] <= stk[i+1];
          end
        end
        2'd1: begin
          stk[0] <= req.value;
        end
        2'd0: begin
          stk[0] <= req.value;
          for (int i = 1; i < STACK_DEPTH; i++) begin
            stk[i] <= stk[i-1];
          end
        end
        default: begin
          stk[0] <= stk[0];
        end
      endcase
    end
  end

  `PFE_ASSERT(a_count_bound, clk, rst, count <= CW'(STACK_DEPTH), "stack count past depth")
  `PFE_ASSERT_NEXT(a_restart, clk, rst, restart, (count == CW'(1)) && (stk[0] == 16'd1), "restart did not seed stack")
  `PFE_ASSERT_NEXT(a_push_top, clk, rst, en && !restart && req.push && !fault, pop_a == $past(req.value), "pushed word not on top")

endmodule

// File: design/postfix_item_predicate_eval.sv
// Top level of the postfix item predicate evaluator.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+--------------------------------------
//   in      | input     | in_valid / in_stall  | script_byte, last_byte
//   out     | output    | out_valid / out_stall| verdict, no_terminator, flags
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One script byte per cycle while in_stall is low: a byte is registered, then evaluated
// against the top two stack entries, and a result word lands in the output register.
// out_valid rises once a last or end byte has been evaluated, unless a
// stalled result still holds the output register.
// The input register acts as a skid stage; in_stall rises only while a result waits
// in the output register and out_stall holds it there.
// rst is synchronous: stack seeded with 1, flags and operand phase cleared, registers 0.
// cfg_ready is always high; each accepted register write is registered.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module postfix_item_predicate_eval #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfe_pkg::byte_t    script_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              verdict,
  output logic              no_terminator,
  output logic              unknown_opcode_seen,
  output logic              stack_fault,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pfe_pkg::reg_idx_t cfg_index,
  input  pfe_pkg::word_t    cfg_data
);
  import pfe_pkg::*;

  reg_file_t   regs;
  logic        in_q_valid;
  byte_t       byte_q;
  logic        last_q;
  eval_state_t state;
  eval_state_t state_next;
  stack_req_t  req;
  step_info_t  info;
  word_t       pop_a;
  word_t       pop_c;
  logic        fault_now;
  logic        finished;
  logic        unknown_flag;
  logic        fault_flag;
  logic        unknown_next;
  logic        fault_next;
  logic        adv;
  logic        fire;
  logic        emit;
  logic        restart;
  logic        stack_en;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index < reg_idx_t'(NUM_REGS))) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // input skid register
  assign adv      = !out_valid || !out_stall;
  assign fire     = in_q_valid && adv;
  assign in_stall = in_q_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= script_byte;
      last_q <= last_byte;
    end
  end

  // evaluation
  pfe_decode u_decode (
    .script_byte (byte_q),
    .state       (state),
    .regs        (regs),
    .pop_a       (pop_a),
    .pop_c       (pop_c),
    .state_next  (state_next),
    .req         (req),
    .info        (info)
  );

  pfe_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .en      (stack_en),
    .restart (restart),
    .req     (req),
    .pop_a   (pop_a),
    .pop_c   (pop_c),
    .fault   (fault_now)
  );

  always_comb begin
    stack_en     = fire && !finished;
    emit         = !finished && (info.is_end || last_q);
    restart      = fire && last_q && (finished || emit);
    unknown_next = unknown_flag | info.unknown;
    fault_next   = fault_flag | fault_now;
  end

  // script state: operand phase, flags, early finish
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state        <= EVAL_IDLE;
      finished     <= 1'b0;
      unknown_flag <= 1'b0;
      fault_flag   <= 1'b0;
    end else if (stack_en) begin
      state        <= state_next;
      finished     <= emit;
      unknown_flag <= unknown_next;
      fault_flag   <= fault_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      verdict             <= info.is_end && info.verdict;
      no_terminator       <= !info.is_end;
      unknown_opcode_seen <= unknown_next;
      stack_fault         <= fault_next;
    end
  end

  `PFE_ASSERT(a_stall_cause, clk, rst, !in_stall || (out_valid && out_stall), "needless stall")
  `PFE_ASSERT_NEXT(a_skip_quiet, clk, rst, fire && finished, !out_valid, "result after end opcode")
  `PFE_ASSERT_NEXT(a_last_emits, clk, rst, fire && !finished && last_q, out_valid, "no result")

endmodule
